// File: rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants
// Field widths, slot state codes, command codes and the sequencer state type
// of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int TASK_SLOTS_DEF = 16;

   localparam int CMD_W     = 2;
   localparam int SP_W      = 64;
   localparam int OUT_IDX_W = 4;

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd2;

   typedef enum logic [1:0] {
      SLOT_TERMINATED = 2'd0,
      SLOT_READY      = 2'd1,
      SLOT_RUNNING    = 2'd2
   } slot_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CUR_RD,
      ST_CUR_CHK,
      ST_SCAN,
      ST_DEMOTE,
      ST_PROMOTE,
      ST_RESULT
   } sched_state_type;

endpackage

// File: rtl/rrts_req_if.sv
// ----------------------------------------------------------------------------
// rrts_req_if: command channel
// Valid/ready channel that carries one scheduler command per transfer.
// ----------------------------------------------------------------------------
interface rrts_req_if import rrts_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [SP_W-1:0]  current_sp;
   logic [SP_W-1:0]  new_task_sp;

   modport source (output valid, output cmd, output current_sp, output new_task_sp,
                   input ready);
   modport sink   (input valid, input cmd, input current_sp, input new_task_sp,
                   output ready);
endinterface

// File: rtl/rrts_rsp_if.sv
// ----------------------------------------------------------------------------
// rrts_rsp_if: result channel
// Valid/ready channel that carries one scheduler result per transfer.
// ----------------------------------------------------------------------------
interface rrts_rsp_if import rrts_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 switched;
   logic [SP_W-1:0]      next_sp;
   logic [OUT_IDX_W-1:0] new_index;
   logic                 status;
   logic [OUT_IDX_W-1:0] running_task;

   modport source (output valid, output switched, output next_sp, output new_index,
                   output status, output running_task, input ready);
   modport sink   (input valid, input switched, input next_sp, input new_index,
                   input status, input running_task, output ready);
endinterface

// File: rtl/round_robin_task_scheduler.sv
// Throughput: one command at a time; the next one can be taken in the cycle
//   after its result is posted; posting waits while an older result is held.
// Reset: synchronous; slot 0 running, others terminated, through per-slot
//   valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// round_robin_task_scheduler: round-robin task table
// Keeps per-slot task state and saved stack pointer, creates and exits tasks
// and picks the next ready task on each timer tick by a sequential scan.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler import rrts_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
   input logic        clock,
   input logic        reset,
   rrts_req_if.sink   req_chan,
   rrts_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(TASK_SLOTS);
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);
   localparam int EXT_W = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
   localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(TASK_SLOTS);

   sched_state_type state_ff, state_in;

   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [SP_W-1:0]      cur_sp_ff, cur_sp_in;
   logic [SP_W-1:0]      new_sp_ff, new_sp_in;
   logic [IDX_W-1:0]     run_idx_ff, run_idx_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic                 was_run_ff, was_run_in;
   logic [IDX_W-1:0]     scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]     issue_cnt_ff, issue_cnt_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]     found_ff, found_in;
   logic                 res_switched_ff, res_switched_in;
   logic                 res_status_ff, res_status_in;
   logic [OUT_IDX_W-1:0] res_index_ff, res_index_in;
   logic [TASK_SLOTS-1:0] slot_vld_ff, slot_vld_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_switched_ff, rsp_switched_in;
   logic [SP_W-1:0]      rsp_next_sp_ff, rsp_next_sp_in;
   logic [OUT_IDX_W-1:0] rsp_new_index_ff, rsp_new_index_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [OUT_IDX_W-1:0] rsp_running_ff, rsp_running_in;

   // task table memories
   slot_code_type        state_mem_ff [TASK_SLOTS];
   logic [SP_W-1:0]      sp_mem_ff [TASK_SLOTS];
   slot_code_type        st_rd_ff;
   logic [SP_W-1:0]      sp_rd_ff;

   logic                 st_we;
   logic [IDX_W-1:0]     st_wr_addr;
   slot_code_type        st_wr_data;
   logic [IDX_W-1:0]     st_rd_addr;
   logic                 sp_we;
   logic [IDX_W-1:0]     sp_wr_addr;
   logic [SP_W-1:0]      sp_wr_data;
   logic                 sp_rd_en;
   logic [IDX_W-1:0]     sp_rd_addr;

   slot_code_type        eff_code;
   logic                 scan_match;
   logic                 issuing;
   logic [IDX_W-1:0]     scan_next;
   logic [IDX_W-1:0]     run_next;
   logic [EXT_W-1:0]     rd_idx_ext;
   logic [EXT_W-1:0]     run_idx_ext;
   logic [CNT_W-1:0]     rd_idx_cnt;

   // an entry never written reads as its reset code
   always_comb begin
      if (slot_vld_ff[rd_idx_ff]) begin
         eff_code = st_rd_ff;
      end else if (rd_idx_ff == '0) begin
         eff_code = SLOT_RUNNING;
      end else begin
         eff_code = SLOT_TERMINATED;
      end
   end

   assign rd_idx_cnt  = CNT_W'(rd_idx_ff);
   assign rd_idx_ext  = EXT_W'(rd_idx_ff);
   assign run_idx_ext = EXT_W'(run_idx_ff);
   assign scan_next   = (scan_addr_ff == LAST_IDX) ? '0 : scan_addr_ff + 1'b1;
   assign run_next    = (run_idx_ff == LAST_IDX) ? '0 : run_idx_ff + 1'b1;
   assign issuing     = (issue_cnt_ff != SLOT_CNT);

   always_comb begin
      if (cmd_ff == CMD_TICK) begin
         scan_match = (rd_idx_cnt < used_ff) && (eff_code == SLOT_READY);
      end else begin
         scan_match = (eff_code == SLOT_TERMINATED);
      end
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.switched     = rsp_switched_ff;
   assign rsp_chan.next_sp      = rsp_next_sp_ff;
   assign rsp_chan.new_index    = rsp_new_index_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.running_task = rsp_running_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_idx_ff   <= '0;
         used_ff      <= CNT_W'(1);
         slot_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_idx_ff   <= run_idx_in;
         used_ff      <= used_in;
         slot_vld_ff  <= slot_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      cur_sp_ff        <= cur_sp_in;
      new_sp_ff        <= new_sp_in;
      was_run_ff       <= was_run_in;
      scan_addr_ff     <= scan_addr_in;
      issue_cnt_ff     <= issue_cnt_in;
      rd_idx_ff        <= rd_idx_in;
      found_ff         <= found_in;
      res_switched_ff  <= res_switched_in;
      res_status_ff    <= res_status_in;
      res_index_ff     <= res_index_in;
      rsp_switched_ff  <= rsp_switched_in;
      rsp_next_sp_ff   <= rsp_next_sp_in;
      rsp_new_index_ff <= rsp_new_index_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_running_ff   <= rsp_running_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         state_mem_ff[st_wr_addr] <= st_wr_data;
      end
      st_rd_ff <= state_mem_ff[st_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (sp_we) begin
         sp_mem_ff[sp_wr_addr] <= sp_wr_data;
      end
      if (sp_rd_en) begin
         sp_rd_ff <= sp_mem_ff[sp_rd_addr];
      end
   end

   always_comb begin
      slot_vld_in = slot_vld_ff;
      if (st_we) begin
         slot_vld_in[st_wr_addr] = 1'b1;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      cur_sp_in        = cur_sp_ff;
      new_sp_in        = new_sp_ff;
      run_idx_in       = run_idx_ff;
      used_in          = used_ff;
      was_run_in       = was_run_ff;
      scan_addr_in     = scan_addr_ff;
      issue_cnt_in     = issue_cnt_ff;
      rd_pend_in       = 1'b0;
      rd_idx_in        = rd_idx_ff;
      found_in         = found_ff;
      res_switched_in  = res_switched_ff;
      res_status_in    = res_status_ff;
      res_index_in     = res_index_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_switched_in  = rsp_switched_ff;
      rsp_next_sp_in   = rsp_next_sp_ff;
      rsp_new_index_in = rsp_new_index_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_running_in   = rsp_running_ff;
      st_we            = 1'b0;
      st_wr_addr       = run_idx_ff;
      st_wr_data       = SLOT_TERMINATED;
      st_rd_addr       = scan_addr_ff;
      sp_we            = 1'b0;
      sp_wr_addr       = run_idx_ff;
      sp_wr_data       = cur_sp_ff;
      sp_rd_en         = 1'b0;
      sp_rd_addr       = found_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in          = req_chan.cmd;
               cur_sp_in       = req_chan.current_sp;
               new_sp_in       = req_chan.new_task_sp;
               res_switched_in = 1'b0;
               res_status_in   = 1'b0;
               res_index_in    = '0;
               scan_addr_in    = '0;
               issue_cnt_in    = '0;
               case (req_chan.cmd)
                  CMD_TICK: begin
                     state_in = ST_CUR_RD;
                  end
                  CMD_CREATE: begin
                     state_in = ST_SCAN;
                  end
                  CMD_EXIT: begin
                     st_we    = 1'b1;
                     state_in = ST_RESULT;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_CUR_RD: begin
            st_rd_addr = run_idx_ff;
            rd_idx_in  = run_idx_ff;
            state_in   = ST_CUR_CHK;
         end
         ST_CUR_CHK: begin
            was_run_in = (eff_code == SLOT_RUNNING);
            sp_we      = (eff_code == SLOT_RUNNING);
            // search starts one past the running slot
            scan_addr_in = run_next;
            issue_cnt_in = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_pend_ff && scan_match) begin
               found_in = rd_idx_ff;
               if (cmd_ff == CMD_TICK) begin
                  state_in = ST_DEMOTE;
               end else begin
                  st_we        = 1'b1;
                  st_wr_addr   = rd_idx_ff;
                  st_wr_data   = SLOT_READY;
                  sp_we        = 1'b1;
                  sp_wr_addr   = rd_idx_ff;
                  sp_wr_data   = new_sp_ff;
                  if (rd_idx_cnt >= used_ff) begin
                     used_in = rd_idx_cnt + 1'b1;
                  end
                  res_index_in = rd_idx_ext[OUT_IDX_W-1:0];
                  state_in     = ST_RESULT;
               end
            end else if (issuing) begin
               st_rd_addr   = scan_addr_ff;
               rd_idx_in    = scan_addr_ff;
               rd_pend_in   = 1'b1;
               scan_addr_in = scan_next;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end else begin
               res_status_in = (cmd_ff == CMD_CREATE);
               state_in      = ST_RESULT;
            end
         end
         ST_DEMOTE: begin
            st_we      = was_run_ff;
            st_wr_addr = run_idx_ff;
            st_wr_data = SLOT_READY;
            sp_rd_en   = 1'b1;
            sp_rd_addr = found_ff;
            state_in   = ST_PROMOTE;
         end
         ST_PROMOTE: begin
            st_we           = 1'b1;
            st_wr_addr      = found_ff;
            st_wr_data      = SLOT_RUNNING;
            run_idx_in      = found_ff;
            res_switched_in = 1'b1;
            state_in        = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_switched_in  = res_switched_ff;
               rsp_next_sp_in   = res_switched_ff ? sp_rd_ff : '0;
               rsp_new_index_in = res_index_ff;
               rsp_status_in    = res_status_ff;
               rsp_running_in   = run_idx_ext[OUT_IDX_W-1:0];
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
